@@ rtl/core/mtg_pkg.sv @@
// Shared types and constants of the MT19937 generator.
// No dependencies; every other file in rtl/core imports this package.
package mtg_pkg;

  localparam int unsigned STATE_DEPTH  = 624;
  localparam int unsigned TWIST_OFFSET = 397;
  localparam int unsigned WORD_W       = 32;
  localparam int unsigned FILL_CNT_W   = $clog2(STATE_DEPTH);

  localparam int unsigned INIT_SHIFT = 30;
  localparam int unsigned TEMPER_U   = 11;
  localparam int unsigned TEMPER_S   = 7;
  localparam int unsigned TEMPER_T   = 15;
  localparam int unsigned TEMPER_L   = 18;

  typedef logic [WORD_W-1:0] word_t;

  localparam word_t INIT_MULT    = 32'h6C07_8965;
  localparam word_t DEFAULT_SEED = 32'd5489;
  localparam word_t MATRIX_A     = 32'h9908_B0DF;
  localparam word_t UPPER_MASK   = 32'h8000_0000;
  localparam word_t LOWER_MASK   = 32'h7FFF_FFFF;
  localparam word_t TEMPER_B     = 32'h9D2C_5680;
  localparam word_t TEMPER_C     = 32'hEFC6_0000;

  typedef enum logic {
    CMD_DRAW   = 1'b0,
    CMD_RESEED = 1'b1
  } cmd_e;

  typedef struct packed {
    logic                  fill;
    logic                  first;
    logic [FILL_CNT_W-1:0] idx;
  } feed_ctrl_t;

endpackage

@@ rtl/core/mtg_cell.sv @@
// One word of the state chain: loads its neighbor's word on each shift.
// Depends on mtg_pkg.
module mtg_cell
  import mtg_pkg::*;
(
  input  logic  clk_i,
  input  logic  shift_i,
  input  word_t word_i,
  output word_t word_o
);

  word_t word_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      word_q <= word_i;
    end
  end

  assign word_o = word_q;

endmodule

@@ rtl/core/mtg_feed.sv @@
// New word entering the tail of the chain: twist of the head taps, or the
// seed initialization recurrence on the tail word. Depends on mtg_pkg.
module mtg_feed
  import mtg_pkg::*;
(
  input  feed_ctrl_t ctrl_i,
  input  word_t      seed_i,
  input  word_t      head_i,
  input  word_t      next_i,
  input  word_t      far_i,
  input  word_t      tail_i,
  output word_t      word_o
);

  word_t y;
  word_t twisted;
  word_t mixed;
  word_t prod;
  word_t seeded;

  always_comb begin
    y       = (head_i & UPPER_MASK) | (next_i & LOWER_MASK);
    twisted = far_i ^ (y >> 1) ^ (y[0] ? MATRIX_A : '0);
    mixed   = tail_i ^ (tail_i >> INIT_SHIFT);
    prod    = word_t'(INIT_MULT * mixed);
    seeded  = prod + word_t'(ctrl_i.idx);
    if (ctrl_i.fill) begin
      word_o = ctrl_i.first ? seed_i : seeded;
    end else begin
      word_o = twisted;
    end
  end

endmodule

@@ rtl/core/mtg_out.sv @@
// Output register: tempers the drawn word and holds it until transferred.
// Depends on mtg_pkg.
module mtg_out
  import mtg_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  load_i,
  input  word_t word_i,
  input  logic  out_stall_i,
  output logic  out_valid_o,
  output word_t out_random_word_o
);

  logic  valid_q;
  word_t data_q;
  word_t t1;
  word_t t2;
  word_t t3;
  word_t t4;

  always_comb begin
    t1 = word_i ^ (word_i >> TEMPER_U);
    t2 = t1 ^ ((t1 << TEMPER_S) & TEMPER_B);
    t3 = t2 ^ ((t2 << TEMPER_T) & TEMPER_C);
    t4 = t3 ^ (t3 >> TEMPER_L);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= t4;
    end
  end

  assign out_valid_o       = valid_q;
  assign out_random_word_o = data_q;

endmodule

@@ rtl/core/mersenne_twister_generator.sv @@
// MT19937 generator: a draw returns its tempered word in the cycle after transfer;
// draws are taken every cycle while no fill runs and the result side does not
// stall, the 624-word chain twisting one word per shift.
// A reseed writes the seed at transfer and stalls the input while the chain
// refills, one multiply of the seed recurrence per cycle.
// After reset a fill runs with seed 5489 before the first transfer.
// Depends on mtg_pkg, mtg_cell, mtg_feed and mtg_out.
module mersenne_twister_generator
  import mtg_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  logic  in_cmd_i,
  input  word_t in_seed_i,
  output logic  out_valid_o,
  input  logic  out_stall_i,
  output word_t out_random_word_o
);

  logic                  fill_busy_q;
  logic [FILL_CNT_W-1:0] fill_cnt_q;
  logic                  in_xfer;
  logic                  draw_xfer;
  logic                  reseed_xfer;
  logic                  shift_en;
  feed_ctrl_t            feed_ctrl;
  word_t                 feed_seed;
  word_t                 feed_word;
  word_t                 chain [STATE_DEPTH];

  assign in_stall_o  = fill_busy_q || (out_valid_o && out_stall_i);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign draw_xfer   = in_xfer && (in_cmd_i == CMD_DRAW);
  assign reseed_xfer = in_xfer && (in_cmd_i == CMD_RESEED);
  assign shift_en    = fill_busy_q || in_xfer;

  always_comb begin
    feed_ctrl.fill  = fill_busy_q || reseed_xfer;
    feed_ctrl.first = fill_busy_q ? (fill_cnt_q == '0) : 1'b1;
    feed_ctrl.idx   = fill_cnt_q;
    feed_seed       = fill_busy_q ? DEFAULT_SEED : in_seed_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_busy_q <= 1'b1;
      fill_cnt_q  <= '0;
    end else if (reseed_xfer) begin
      fill_busy_q <= 1'b1;
      fill_cnt_q  <= FILL_CNT_W'(1);
    end else if (fill_busy_q) begin
      if (fill_cnt_q == FILL_CNT_W'(STATE_DEPTH - 1)) begin
        fill_busy_q <= 1'b0;
        fill_cnt_q  <= '0;
      end else begin
        fill_cnt_q <= fill_cnt_q + FILL_CNT_W'(1);
      end
    end
  end

  for (genvar i = 0; i < STATE_DEPTH; i++) begin : g_cell
    if (i == STATE_DEPTH - 1) begin : g_tail
      mtg_cell u_cell (
        .clk_i   (clk_i),
        .shift_i (shift_en),
        .word_i  (feed_word),
        .word_o  (chain[i])
      );
    end else begin : g_body
      mtg_cell u_cell (
        .clk_i   (clk_i),
        .shift_i (shift_en),
        .word_i  (chain[i+1]),
        .word_o  (chain[i])
      );
    end
  end

  mtg_feed u_feed (
    .ctrl_i (feed_ctrl),
    .seed_i (feed_seed),
    .head_i (chain[0]),
    .next_i (chain[1]),
    .far_i  (chain[TWIST_OFFSET]),
    .tail_i (chain[STATE_DEPTH-1]),
    .word_o (feed_word)
  );

  mtg_out u_out (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .load_i            (draw_xfer),
    .word_i            (feed_word),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .out_random_word_o (out_random_word_o)
  );

`ifndef SYNTH
  a_fill_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_busy_q |-> (fill_cnt_q < FILL_CNT_W'(STATE_DEPTH)))
    else $error("fill counter beyond chain depth");

  a_fill_full_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(fill_busy_q) |-> ($past(fill_cnt_q) == FILL_CNT_W'(STATE_DEPTH - 1)))
    else $error("fill ended before the whole chain was written");

  a_reseed_starts_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    reseed_xfer |=> (fill_busy_q && (fill_cnt_q == FILL_CNT_W'(1))))
    else $error("reseed transfer did not start a fill");

  a_result_from_draw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(draw_xfer))
    else $error("result appeared without a draw transfer");
`endif

endmodule
